[src/stale_timestamp_filter_core_defines.svh]
`ifndef STALE_TIMESTAMP_FILTER_CORE_DEFINES_SVH
`define STALE_TIMESTAMP_FILTER_CORE_DEFINES_SVH

// same-cycle implication
`define STF_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/stf_pkg.sv]
package stf_pkg;

    localparam logic [1:0] OP_PLAYER  = 2'd0;
    localparam logic [1:0] OP_VEHICLE = 2'd1;
    localparam logic [1:0] OP_MARKER  = 2'd2;

    localparam int unsigned PLAYER_CHANS  = 6;
    localparam int unsigned VEHICLE_CHANS = 2;
    localparam logic [2:0]  CH_FIRST_VEHICLE = 3'd6;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        V_ACCEPT  = 2'd0,
        V_STALE   = 2'd1,
        V_INVALID = 2'd2,
        V_RANGE   = 2'd3
    } t_verdict;

    typedef enum logic [1:0] {
        T_NONE,
        T_PLAYER,
        T_VEHICLE,
        T_MARKER
    } t_target;

    typedef struct packed {
        t_target     target;
        t_verdict    verdict;
        logic [15:0] id;
        logic [2:0]  ch;
        logic [31:0] stamp;
    } t_req;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK
    } t_bstate;

endpackage

[src/stf_ram.sv]
module stf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/stf_front.sv]
module stf_front import stf_pkg::*; #(
    parameter int PLAYER_SLOTS  = 1024,
    parameter int VEHICLE_SLOTS = 2048
) (
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_entity_id,
    input  logic [2:0]  i_channel,
    input  logic [31:0] i_stamp,
    input  logic        i_busy,
    input  logic        i_q_ready,
    output logic        o_push,
    output t_req        o_req
);

    logic stamp_zero;
    logic player_bad;
    logic vehicle_bad;

    assign stamp_zero  = (i_stamp == 32'd0);
    assign player_bad  = ({1'b0, i_entity_id} >= 17'(PLAYER_SLOTS));
    assign vehicle_bad = ({1'b0, i_entity_id} >= 17'(VEHICLE_SLOTS));

    assign o_ready = i_q_ready && !i_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_req.id      = i_entity_id;
        o_req.ch      = i_channel;
        o_req.stamp   = i_stamp;
        o_req.target  = T_NONE;
        o_req.verdict = V_ACCEPT;
        unique case (i_opcode)
            OP_PLAYER: begin
                priority if (player_bad) begin
                    o_req.verdict = V_INVALID;
                end else if (stamp_zero || i_channel >= CH_FIRST_VEHICLE) begin
                    o_req.verdict = V_ACCEPT;
                end else begin
                    o_req.target = T_PLAYER;
                end
            end
            OP_VEHICLE: begin
                priority if (vehicle_bad) begin
                    o_req.verdict = V_RANGE;
                end else if (stamp_zero || i_channel < CH_FIRST_VEHICLE) begin
                    o_req.verdict = V_ACCEPT;
                end else begin
                    o_req.target = T_VEHICLE;
                end
            end
            OP_MARKER: begin
                if (!stamp_zero) begin
                    o_req.target = T_MARKER;
                end
            end
            default: begin
                o_req.verdict = V_INVALID;
            end
        endcase
    end

endmodule

[src/stf_queue.sv]
module stf_queue import stf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    output logic o_ready,
    output logic o_valid,
    output t_req o_req,
    input  logic i_pop
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_req          r_slot [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    assign o_ready = (r_count != CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_req   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/stf_back.sv]
module stf_back import stf_pkg::*; #(
    parameter int PLAYER_SLOTS  = 1024,
    parameter int VEHICLE_SLOTS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_req        i_q_req,
    output logic        o_pop,
    output logic        o_busy,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_accepted_count,
    output logic [31:0] o_stale_count,
    output logic [31:0] o_invalid_count,
    output logic [31:0] o_range_count
);

`include "stale_timestamp_filter_core_defines.svh"

    localparam int P_DEPTH = PLAYER_SLOTS * PLAYER_CHANS;
    localparam int V_DEPTH = VEHICLE_SLOTS * VEHICLE_CHANS;
    localparam int C_DEPTH = (P_DEPTH > V_DEPTH) ? P_DEPTH : V_DEPTH;
    localparam int P_AW    = $clog2(P_DEPTH);
    localparam int V_AW    = $clog2(V_DEPTH);
    localparam int C_AW    = $clog2(C_DEPTH);

    t_bstate r_state, n_state;
    logic [C_AW-1:0] r_clr, n_clr;
    t_req r_item, n_item;
    logic [P_AW-1:0] r_paddr, n_paddr;
    logic [V_AW-1:0] r_vaddr, n_vaddr;
    logic [31:0] r_marker, n_marker;
    logic [31:0] r_acc, n_acc;
    logic [31:0] r_stl, n_stl;
    logic [31:0] r_inv, n_inv;
    logic [31:0] r_rng, n_rng;
    logic        r_out_valid, n_out_valid;
    t_verdict    r_verdict, n_verdict;

    logic            p_we, v_we, p_re, v_re;
    logic [P_AW-1:0] p_waddr;
    logic [V_AW-1:0] v_waddr;
    logic [31:0]     wdata;
    logic [31:0]     p_rdata, v_rdata;
    logic [31:0]     stored;
    logic [31:0]     diff;
    logic            newer;
    logic            out_free;
    logic            load;
    t_verdict        verdict;

    stf_ram #(.WIDTH(32), .DEPTH(P_DEPTH)) u_player_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (wdata),
        .i_re    (p_re),
        .i_raddr (n_paddr),
        .o_rdata (p_rdata)
    );

    stf_ram #(.WIDTH(32), .DEPTH(V_DEPTH)) u_vehicle_ram (
        .i_clk   (i_clk),
        .i_we    (v_we),
        .i_waddr (v_waddr),
        .i_wdata (wdata),
        .i_re    (v_re),
        .i_raddr (n_vaddr),
        .o_rdata (v_rdata)
    );

    // entry address from the queue head
    assign n_paddr = P_AW'(19'(i_q_req.id) * 19'(PLAYER_CHANS) + 19'(i_q_req.ch));
    assign n_vaddr = V_AW'({i_q_req.id, i_q_req.ch[0]});

    always_comb begin
        unique case (r_item.target)
            T_PLAYER:  stored = p_rdata;
            T_VEHICLE: stored = v_rdata;
            T_MARKER:  stored = r_marker;
            default:   stored = 32'd0;
        endcase
    end

    // serial number compare
    assign diff     = r_item.stamp - stored;
    assign newer    = (stored == 32'd0) || ((diff != 32'd0) && !diff[31]);
    assign verdict  = (r_item.target == T_NONE) ? r_item.verdict
                    : (newer ? V_ACCEPT : V_STALE);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_item      = r_item;
        n_marker    = r_marker;
        n_acc       = r_acc;
        n_stl       = r_stl;
        n_inv       = r_inv;
        n_rng       = r_rng;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid && !i_ready;
        o_pop       = 1'b0;
        p_re        = 1'b0;
        v_re        = 1'b0;
        p_we        = 1'b0;
        v_we        = 1'b0;
        p_waddr     = r_paddr;
        v_waddr     = r_vaddr;
        wdata       = r_item.stamp;
        load        = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                wdata   = 32'd0;
                p_waddr = P_AW'(r_clr);
                v_waddr = V_AW'(r_clr);
                p_we    = (32'(r_clr) < P_DEPTH);
                v_we    = (32'(r_clr) < V_DEPTH);
                n_clr   = r_clr + 1'b1;
                if (r_clr == C_AW'(C_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop   = 1'b1;
                    n_item  = i_q_req;
                    p_re    = (i_q_req.target == T_PLAYER);
                    v_re    = (i_q_req.target == T_VEHICLE);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (out_free) begin
                    load        = 1'b1;
                    n_out_valid = 1'b1;
                    n_verdict   = verdict;
                    if (verdict == V_ACCEPT) begin
                        p_we = (r_item.target == T_PLAYER);
                        v_we = (r_item.target == T_VEHICLE);
                        if (r_item.target == T_MARKER) begin
                            n_marker = r_item.stamp;
                        end
                    end
                    unique case (verdict)
                        V_ACCEPT:  n_acc = r_acc + 32'd1;
                        V_STALE:   n_stl = r_stl + 32'd1;
                        V_INVALID: n_inv = r_inv + 32'd1;
                        V_RANGE:   n_rng = r_rng + 32'd1;
                        default:   n_acc = r_acc;
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_marker    <= '0;
            r_acc       <= '0;
            r_stl       <= '0;
            r_inv       <= '0;
            r_rng       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_marker    <= n_marker;
            r_acc       <= n_acc;
            r_stl       <= n_stl;
            r_inv       <= n_inv;
            r_rng       <= n_rng;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_verdict <= n_verdict;
        if (o_pop) begin
            r_paddr <= n_paddr;
            r_vaddr <= n_vaddr;
        end
    end

    assign o_busy           = (r_state == S_CLEAR);
    assign o_valid          = r_out_valid;
    assign o_verdict        = r_verdict;
    assign o_accepted_count = r_acc;
    assign o_stale_count    = r_stl;
    assign o_invalid_count  = r_inv;
    assign o_range_count    = r_rng;

    `STF_ASSERT_NOW(a_no_pop_in_clear, i_clk, i_rst_n, r_state == S_CLEAR, !o_pop,
        "request taken during clearing pass")
    `STF_ASSERT_NOW(a_write_only_on_accept, i_clk, i_rst_n,
        (r_state == S_CHECK) && (p_we || v_we), load && (verdict == V_ACCEPT),
        "table written without an accepted request")
    `STF_ASSERT_NEXT(a_one_count_per_result, i_clk, i_rst_n, load,
        (r_acc + r_stl + r_inv + r_rng)
            == ($past(r_acc) + $past(r_stl) + $past(r_inv) + $past(r_rng) + 32'd1),
        "counters did not advance by exactly one")

endmodule

[src/stale_timestamp_filter_core.sv]
// stale timestamp filter: freshness check of packet timestamps
// input channel: i_valid / o_ready with opcode, entity id, channel and stamp
// output channel: o_valid / i_ready with a verdict and the four event counters
// every request gives exactly one result, in request order
// a front stage classifies each request into a two-entry queue; the back end
// reads the last-stamp entry, then compares and writes back once the output
// register is free; it takes one request at a time and pops the next only
// after the compare and write-back of the last
// a request passes the queue, the table read and the compare before o_valid rises
// after reset a clearing pass zeroes the tables; it walks
// max(PLAYER_SLOTS*6, VEHICLE_SLOTS*2) entries with o_ready low
// counters and the marker entry clear at reset
// when the receiver stalls the result holds in the output register, the
// queue fills, then o_ready drops
module stale_timestamp_filter_core import stf_pkg::*; #(
    parameter int PLAYER_SLOTS  = 1024,
    parameter int VEHICLE_SLOTS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_entity_id,
    input  logic [2:0]  i_channel,
    input  logic [31:0] i_stamp,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_verdict,
    output logic [31:0] o_accepted_count,
    output logic [31:0] o_stale_count,
    output logic [31:0] o_invalid_count,
    output logic [31:0] o_range_count
);

    logic busy;
    logic q_ready;
    logic push;
    logic q_valid;
    logic pop;
    t_req front_req;
    t_req q_req;

    stf_front #(
        .PLAYER_SLOTS  (PLAYER_SLOTS),
        .VEHICLE_SLOTS (VEHICLE_SLOTS)
    ) u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_entity_id (i_entity_id),
        .i_channel   (i_channel),
        .i_stamp     (i_stamp),
        .i_busy      (busy),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_req       (front_req)
    );

    stf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (front_req),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_req   (q_req),
        .i_pop   (pop)
    );

    stf_back #(
        .PLAYER_SLOTS  (PLAYER_SLOTS),
        .VEHICLE_SLOTS (VEHICLE_SLOTS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_req          (q_req),
        .o_pop            (pop),
        .o_busy           (busy),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_verdict        (o_verdict),
        .o_accepted_count (o_accepted_count),
        .o_stale_count    (o_stale_count),
        .o_invalid_count  (o_invalid_count),
        .o_range_count    (o_range_count)
    );

endmodule
